@@ hw/rtl/pge_pkg.sv @@
// palette gun expander: shared types, codes and defaults
// used by pge_gun_format and palette_gun_expander_unit; no dependencies
package pge_pkg;

  localparam int MAX_COLORS_DEF = 256;
  localparam int GUN_W          = 8;
  localparam int ENTRY_W        = 3 * GUN_W;
  localparam int WIDE_W         = 32;
  localparam int PACK_W         = 12;
  localparam int IDX_W          = 8;
  localparam int TOTAL_W        = 9;
  localparam int PLANE_W        = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;
  localparam logic [PLANE_W-1:0] PLANE_ALL    = 5'd31;
  localparam logic [PLANE_W-1:0] PLANE_RESET  = 5'd8;
  localparam logic [3:0]         NIBBLE_ZERO  = 4'h0;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_EIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_EIGHT   = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // control that travels with a store read to the formatter
  typedef struct packed {
    logic valid;
    logic dup;
  } fmt_ctrl_t;

endpackage

@@ hw/rtl/pge_gun_format.sv @@
// palette gun expander: turns one stored entry into wide guns and a 4-4-4 word
// depends on pge_pkg
module pge_gun_format (
  input  logic [pge_pkg::ENTRY_W-1:0] entry,
  input  pge_pkg::fmt_ctrl_t          ctrl,
  output logic [pge_pkg::WIDE_W-1:0]  red_wide,
  output logic [pge_pkg::WIDE_W-1:0]  green_wide,
  output logic [pge_pkg::WIDE_W-1:0]  blue_wide,
  output logic [pge_pkg::PACK_W-1:0]  packed_twelve
);

  logic [pge_pkg::GUN_W-1:0] red_gun;
  logic [pge_pkg::GUN_W-1:0] green_gun;
  logic [pge_pkg::GUN_W-1:0] blue_gun;

  // when dup is set the upper nibble is or-ed into the low nibble, unchecked entries may keep low bits
  function automatic logic [pge_pkg::WIDE_W-1:0] widen(
    input logic [pge_pkg::GUN_W-1:0] gun,
    input logic                      dup
  );
    logic [pge_pkg::GUN_W-1:0] g;
    g = dup ? {gun[7:4], gun[3:0] | gun[7:4]} : gun;
    return {g, g, g, g};
  endfunction

  assign red_gun   = entry[23:16];
  assign green_gun = entry[15:8];
  assign blue_gun  = entry[7:0];

  always_comb begin
    if (ctrl.valid) begin
      red_wide      = widen(red_gun, ctrl.dup);
      green_wide    = widen(green_gun, ctrl.dup);
      blue_wide     = widen(blue_gun, ctrl.dup);
      packed_twelve = {red_gun[7:4], green_gun[7:4], blue_gun[7:4]};
    end else begin
      red_wide      = '0;
      green_wide    = '0;
      blue_wide     = '0;
      packed_twelve = '0;
    end
  end

endmodule

@@ hw/rtl/palette_gun_expander_unit.sv @@
// palette gun expander top: color store, load count, marks and output register
// depends on pge_pkg and pge_gun_format
//
// channel | handshake            | payload
// in      | in_valid / in_ready  | func, first, red_in, green_in, blue_in, read_index
// out     | out_valid / out_ready| red_wide .. overflow
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a load item goes straight to the output register; a read item passes the store
// read port (registered read data), then is formatted into the output register
// rst is synchronous; it clears count and drop mark and sets the shifted mark, store contents stay undefined
// in_ready is low while a read is in flight or the output register is held
// cfg_ready is always high
module palette_gun_expander_unit #(
  parameter int MAX_COLORS = pge_pkg::MAX_COLORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic                            first,
  input  logic [pge_pkg::GUN_W-1:0]       red_in,
  input  logic [pge_pkg::GUN_W-1:0]       green_in,
  input  logic [pge_pkg::GUN_W-1:0]       blue_in,
  input  logic [pge_pkg::IDX_W-1:0]       read_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pge_pkg::WIDE_W-1:0]      red_wide,
  output logic [pge_pkg::WIDE_W-1:0]      green_wide,
  output logic [pge_pkg::WIDE_W-1:0]      blue_wide,
  output logic [pge_pkg::PACK_W-1:0]      packed_twelve,
  output logic                            entry_valid,
  output logic [pge_pkg::TOTAL_W-1:0]     loaded_total,
  output logic                            nibbles_shifted,
  output logic                            overflow,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pge_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pge_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_COLORS);
  localparam int CNT_W  = $clog2(MAX_COLORS + 1);
  localparam int CMP_W  = (CNT_W > pge_pkg::IDX_W) ? CNT_W : pge_pkg::IDX_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_COLORS);

  logic [pge_pkg::ENTRY_W-1:0] color_store [MAX_COLORS];
  logic [pge_pkg::ENTRY_W-1:0] rd_data;

  pge_pkg::state_t state, state_next;

  logic [pge_pkg::PLANE_W-1:0] plane_count;
  logic                        user_eight_bit_ok;
  logic                        file_eight_bit_ok;

  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic             shifted_mark, shifted_mark_next;
  logic             dropped_mark, dropped_mark_next;

  pge_pkg::fmt_ctrl_t rd_ctrl;

  logic             slot_free;
  logic             in_fire;
  logic             load_fire;
  logic             read_fire;
  logic             fmt_load;
  logic [CNT_W-1:0] cnt_base;
  logic             full;
  logic             checked;
  logic             low_nibble_set;
  logic             store_we;
  logic             idx_below;

  logic [pge_pkg::WIDE_W-1:0] fmt_red;
  logic [pge_pkg::WIDE_W-1:0] fmt_green;
  logic [pge_pkg::WIDE_W-1:0] fmt_blue;
  logic [pge_pkg::PACK_W-1:0] fmt_pack;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (func == pge_pkg::FUNC_LOAD);
  assign read_fire = in_fire && (func == pge_pkg::FUNC_READ);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pge_pkg::S_IDLE: begin
        if (read_fire) state_next = pge_pkg::S_READ;
      end
      pge_pkg::S_READ: begin
        if (slot_free) state_next = pge_pkg::S_IDLE;
      end
      default: state_next = pge_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    fmt_load = 1'b0;
    case (state)
      pge_pkg::S_IDLE: in_ready = slot_free;
      pge_pkg::S_READ: fmt_load = slot_free;
      default: begin
        in_ready = 1'b0;
        fmt_load = 1'b0;
      end
    endcase
  end

  // load path
  always_comb begin
    cnt_base          = first ? '0 : entry_count;
    full              = (cnt_base == CNT_FULL);
    checked           = (plane_count >= pge_pkg::PLANE_ALL) ||
                        ((cnt_base >> plane_count) == '0);
    low_nibble_set    = ((red_in[3:0] | green_in[3:0] | blue_in[3:0]) != pge_pkg::NIBBLE_ZERO);
    store_we          = load_fire && !full;
    entry_count_next  = entry_count;
    shifted_mark_next = shifted_mark;
    dropped_mark_next = dropped_mark;
    if (load_fire) begin
      shifted_mark_next = first ? 1'b1 : shifted_mark;
      dropped_mark_next = first ? 1'b0 : dropped_mark;
      if (full) begin
        dropped_mark_next = 1'b1;
        entry_count_next  = cnt_base;
      end else begin
        entry_count_next = cnt_base + CNT_W'(1);
        if (checked && low_nibble_set) shifted_mark_next = 1'b0;
      end
    end
  end

  assign idx_below = (CMP_W'(read_index) < CMP_W'(entry_count));

  always_ff @(posedge clk) begin
    if (store_we) begin
      color_store[cnt_base[ADDR_W-1:0]] <= {red_in, green_in, blue_in};
    end
    if (read_fire) begin
      rd_data <= color_store[ADDR_W'(read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= pge_pkg::S_IDLE;
      plane_count       <= pge_pkg::PLANE_RESET;
      user_eight_bit_ok <= 1'b0;
      file_eight_bit_ok <= 1'b0;
      entry_count       <= '0;
      shifted_mark      <= 1'b1;
      dropped_mark      <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state        <= state_next;
      entry_count  <= entry_count_next;
      shifted_mark <= shifted_mark_next;
      dropped_mark <= dropped_mark_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pge_pkg::REG_PLANE_COUNT: plane_count       <= cfg_data;
          pge_pkg::REG_USER_EIGHT:  user_eight_bit_ok <= cfg_data[0];
          pge_pkg::REG_FILE_EIGHT:  file_eight_bit_ok <= cfg_data[0];
          default: ;
        endcase
      end
      if (load_fire || fmt_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      rd_ctrl.valid <= idx_below;
      rd_ctrl.dup   <= !user_eight_bit_ok && !file_eight_bit_ok && shifted_mark;
    end
  end

  pge_gun_format u_format (
    .entry         (rd_data),
    .ctrl          (rd_ctrl),
    .red_wide      (fmt_red),
    .green_wide    (fmt_green),
    .blue_wide     (fmt_blue),
    .packed_twelve (fmt_pack)
  );

  // output register
  always_ff @(posedge clk) begin
    if (load_fire) begin
      red_wide        <= '0;
      green_wide      <= '0;
      blue_wide       <= '0;
      packed_twelve   <= '0;
      entry_valid     <= 1'b0;
      loaded_total    <= pge_pkg::TOTAL_W'(entry_count_next);
      nibbles_shifted <= shifted_mark_next;
      overflow        <= dropped_mark_next;
    end else if (fmt_load) begin
      red_wide        <= fmt_red;
      green_wide      <= fmt_green;
      blue_wide       <= fmt_blue;
      packed_twelve   <= fmt_pack;
      entry_valid     <= rd_ctrl.valid;
      loaded_total    <= pge_pkg::TOTAL_W'(entry_count);
      nibbles_shifted <= shifted_mark;
      overflow        <= dropped_mark;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_FULL)
    else $error("entry count above capacity");

  a_read_enters_wait: assert property (@(posedge clk) disable iff (rst)
    read_fire |=> state == pge_pkg::S_READ)
    else $error("read item did not start store access");

  a_no_accept_in_read: assert property (@(posedge clk) disable iff (rst)
    state == pge_pkg::S_READ |-> !in_ready)
    else $error("item accepted while read in flight");

  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    load_fire && !first && entry_count == CNT_FULL |=> dropped_mark && $stable(entry_count))
    else $error("load into full store not dropped");

endmodule

@@ tb/sv/palette_expand_checker.sv @@
`timescale 1ns / 1ps
// checker for palette_gun_expander_unit: watches the item, result and register channels
// predicts every result from its own palette state and compares field by field; uses pge_pkg
module palette_expand_checker #(
  parameter int COLOR_DEPTH = pge_pkg::MAX_COLORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           func,
  input  logic                           first,
  input  logic [pge_pkg::GUN_W-1:0]      red_in,
  input  logic [pge_pkg::GUN_W-1:0]      green_in,
  input  logic [pge_pkg::GUN_W-1:0]      blue_in,
  input  logic [pge_pkg::IDX_W-1:0]      read_index,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [pge_pkg::WIDE_W-1:0]     red_wide,
  input  logic [pge_pkg::WIDE_W-1:0]     green_wide,
  input  logic [pge_pkg::WIDE_W-1:0]     blue_wide,
  input  logic [pge_pkg::PACK_W-1:0]     packed_twelve,
  input  logic                           entry_valid,
  input  logic [pge_pkg::TOTAL_W-1:0]    loaded_total,
  input  logic                           nibbles_shifted,
  input  logic                           overflow,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pge_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pge_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             outstanding
);

  localparam logic [pge_pkg::GUN_W-1:0] LOW_NIBBLE_MASK = 8'h0F;

  typedef struct packed {
    logic [pge_pkg::WIDE_W-1:0]  red_wide;
    logic [pge_pkg::WIDE_W-1:0]  green_wide;
    logic [pge_pkg::WIDE_W-1:0]  blue_wide;
    logic [pge_pkg::PACK_W-1:0]  packed_twelve;
    logic                        entry_valid;
    logic [pge_pkg::TOTAL_W-1:0] loaded_total;
    logic                        nibbles_shifted;
    logic                        overflow;
  } gun_result_t;

  logic [pge_pkg::ENTRY_W-1:0] color_mem [COLOR_DEPTH];
  int unsigned                 loaded_cnt;
  bit                          all_shifted;
  bit                          drop_seen;
  logic [pge_pkg::PLANE_W-1:0] planes;
  bit                          user_ok;
  bit                          file_ok;
  gun_result_t                 expected_colors[$];

  function automatic logic [pge_pkg::WIDE_W-1:0] widen_gun(logic [pge_pkg::GUN_W-1:0] gun,
                                                           bit dup);
    logic [pge_pkg::GUN_W-1:0] g;
    g = dup ? {gun[7:4], gun[3:0] | gun[7:4]} : gun;
    return {4{g}};
  endfunction

  function automatic bit entry_checked(int unsigned idx);
    if (planes >= pge_pkg::PLANE_ALL) return 1'b1;
    return longint'(idx) < (longint'(1) << planes);
  endfunction

  function automatic gun_result_t predict_palette_item(logic fn, logic fi,
      logic [pge_pkg::GUN_W-1:0] r, logic [pge_pkg::GUN_W-1:0] g,
      logic [pge_pkg::GUN_W-1:0] b, logic [pge_pkg::IDX_W-1:0] idx);
    gun_result_t                 res;
    logic [pge_pkg::ENTRY_W-1:0] ent;
    bit                          dup;
    res = '0;
    if (fn == pge_pkg::FUNC_LOAD) begin
      if (fi) begin
        loaded_cnt  = 0;
        all_shifted = 1'b1;
        drop_seen   = 1'b0;
      end
      if (loaded_cnt >= COLOR_DEPTH) begin
        drop_seen = 1'b1;
      end else begin
        color_mem[loaded_cnt] = {r, g, b};
        if (entry_checked(loaded_cnt) && ((r | g | b) & LOW_NIBBLE_MASK) != '0)
          all_shifted = 1'b0;
        loaded_cnt++;
      end
    end else if (idx < loaded_cnt && idx < COLOR_DEPTH) begin
      ent = color_mem[idx];
      dup = !user_ok && !file_ok && all_shifted;
      res.red_wide      = widen_gun(ent[23:16], dup);
      res.green_wide    = widen_gun(ent[15:8], dup);
      res.blue_wide     = widen_gun(ent[7:0], dup);
      res.packed_twelve = {ent[23:20], ent[15:12], ent[7:4]};
      res.entry_valid   = 1'b1;
    end
    res.loaded_total    = loaded_cnt[pge_pkg::TOTAL_W-1:0];
    res.nibbles_shifted = all_shifted;
    res.overflow        = drop_seen;
    return res;
  endfunction

  task automatic note_mismatch(string what);
    if (fail_count < 40) $display("mismatch @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    gun_result_t want;
    int          delta;
    if (rst) begin
      loaded_cnt  = 0;
      all_shifted = 1'b1;
      drop_seen   = 1'b0;
      planes      = pge_pkg::PLANE_RESET;
      user_ok     = 1'b0;
      file_ok     = 1'b0;
      expected_colors.delete();
      outstanding <= 0;
    end else begin
      delta = 0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pge_pkg::REG_PLANE_COUNT: planes  = cfg_data[pge_pkg::PLANE_W-1:0];
          pge_pkg::REG_USER_EIGHT:  user_ok = cfg_data[0];
          pge_pkg::REG_FILE_EIGHT:  file_ok = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          note_mismatch("result with no item pending");
        end else begin
          want = expected_colors.pop_front();
          delta--;
          if (red_wide !== want.red_wide)
            note_mismatch($sformatf("red_wide %h, expected %h", red_wide, want.red_wide));
          if (green_wide !== want.green_wide)
            note_mismatch($sformatf("green_wide %h, expected %h", green_wide, want.green_wide));
          if (blue_wide !== want.blue_wide)
            note_mismatch($sformatf("blue_wide %h, expected %h", blue_wide, want.blue_wide));
          if (packed_twelve !== want.packed_twelve)
            note_mismatch($sformatf("packed_twelve %h, expected %h",
                                    packed_twelve, want.packed_twelve));
          if (entry_valid !== want.entry_valid)
            note_mismatch($sformatf("entry_valid %b, expected %b", entry_valid, want.entry_valid));
          if (loaded_total !== want.loaded_total)
            note_mismatch($sformatf("loaded_total %0d, expected %0d",
                                    loaded_total, want.loaded_total));
          if (nibbles_shifted !== want.nibbles_shifted)
            note_mismatch($sformatf("nibbles_shifted %b, expected %b",
                                    nibbles_shifted, want.nibbles_shifted));
          if (overflow !== want.overflow)
            note_mismatch($sformatf("overflow %b, expected %b", overflow, want.overflow));
        end
      end
      if (in_valid && in_ready) begin
        expected_colors.push_back(predict_palette_item(func, first, red_in, green_in,
                                                       blue_in, read_index));
        delta++;
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// top of the palette_gun_expander_unit testbench: clock, reset, palette stimulus and verdict
// depends on pge_pkg, palette_gun_expander_unit and palette_expand_checker
module testbench;

  localparam int COLOR_DEPTH = pge_pkg::MAX_COLORS_DEF;
  localparam int PER_PHASE   = 175;
  localparam int CYCLE_LIMIT = 200000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           func = pge_pkg::FUNC_LOAD;
  logic                           first = 1'b0;
  logic [pge_pkg::GUN_W-1:0]      red_in = '0;
  logic [pge_pkg::GUN_W-1:0]      green_in = '0;
  logic [pge_pkg::GUN_W-1:0]      blue_in = '0;
  logic [pge_pkg::IDX_W-1:0]      read_index = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [pge_pkg::WIDE_W-1:0]     red_wide;
  logic [pge_pkg::WIDE_W-1:0]     green_wide;
  logic [pge_pkg::WIDE_W-1:0]     blue_wide;
  logic [pge_pkg::PACK_W-1:0]     packed_twelve;
  logic                           entry_valid;
  logic [pge_pkg::TOTAL_W-1:0]    loaded_total;
  logic                           nibbles_shifted;
  logic                           overflow;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pge_pkg::CFG_IDX_W-1:0]  cfg_index = pge_pkg::REG_PLANE_COUNT;
  logic [pge_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                             fail_count;
  int                             outstanding;

  int send_pct = 0;
  int recv_pct = 0;
  int stim_count = 0;
  int n_items = 0;
  int n_loads = 0;
  int n_reads = 0;
  int n_full = 0;
  int n_settings = 0;
  int cycle_cnt = 0;

  palette_gun_expander_unit #(.MAX_COLORS(COLOR_DEPTH)) u_top (.*);
  palette_expand_checker #(.COLOR_DEPTH(COLOR_DEPTH)) u_check (.*);

  always #6 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_pct);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drive_item(logic fn, logic fi, logic [pge_pkg::GUN_W-1:0] r,
                            logic [pge_pkg::GUN_W-1:0] g, logic [pge_pkg::GUN_W-1:0] b,
                            logic [pge_pkg::IDX_W-1:0] idx);
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    first      <= fi;
    red_in     <= r;
    green_in   <= g;
    blue_in    <= b;
    read_index <= idx;
    do @(posedge clk); while (!in_ready);
    n_items++;
  endtask

  task automatic load_entry(logic fi, logic [pge_pkg::GUN_W-1:0] r,
                            logic [pge_pkg::GUN_W-1:0] g, logic [pge_pkg::GUN_W-1:0] b);
    drive_item(pge_pkg::FUNC_LOAD, fi, r, g, b, pge_pkg::IDX_W'($urandom_range(0, 255)));
    if (fi) stim_count = 1;
    else if (stim_count < COLOR_DEPTH) stim_count++;
    n_loads++;
  endtask

  task automatic read_entry(logic [pge_pkg::IDX_W-1:0] idx);
    drive_item(pge_pkg::FUNC_READ, 1'($urandom_range(0, 1)), pge_pkg::GUN_W'($urandom),
               pge_pkg::GUN_W'($urandom), pge_pkg::GUN_W'($urandom), idx);
    n_reads++;
  endtask

  // wait until every item has produced its result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_regs(logic [pge_pkg::PLANE_W-1:0] planes, logic user_ok,
                            logic file_ok);
    logic [pge_pkg::CFG_IDX_W-1:0]  reg_ids [3];
    logic [pge_pkg::CFG_DATA_W-1:0] reg_vals [3];
    reg_ids  = '{pge_pkg::REG_PLANE_COUNT, pge_pkg::REG_USER_EIGHT, pge_pkg::REG_FILE_EIGHT};
    reg_vals = '{pge_pkg::CFG_DATA_W'(planes), pge_pkg::CFG_DATA_W'(user_ok),
                 pge_pkg::CFG_DATA_W'(file_ok)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data  <= reg_vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [pge_pkg::GUN_W-1:0] make_gun(int noise_pct);
    logic [3:0] lo;
    lo = ($urandom_range(0, 99) < noise_pct) ? 4'($urandom_range(1, 15))
                                             : pge_pkg::NIBBLE_ZERO;
    return {4'($urandom_range(0, 15)), lo};
  endfunction

  function automatic logic [pge_pkg::IDX_W-1:0] pick_index();
    if (stim_count > 0 && $urandom_range(0, 99) < 75)
      return pge_pkg::IDX_W'($urandom_range(0, stim_count - 1));
    return pge_pkg::IDX_W'($urandom_range(0, 255));
  endfunction

  task automatic run_palette(int len, bit restart, int noise_pct);
    for (int i = 0; i < len; i++) begin
      load_entry(restart && i == 0, make_gun(noise_pct), make_gun(noise_pct),
                 make_gun(noise_pct));
      if ($urandom_range(0, 99) < 30) read_entry(pick_index());
      if ($urandom_range(0, 99) < 3) begin
        if ($urandom_range(0, 1) == 0)
          load_entry(1'($urandom_range(0, 1)), pge_pkg::GUN_W'($urandom),
                     pge_pkg::GUN_W'($urandom), pge_pkg::GUN_W'($urandom));
        else
          read_entry(pge_pkg::IDX_W'($urandom));
      end
    end
    repeat (2) read_entry(pick_index());
  endtask

  initial begin
    logic [pge_pkg::PLANE_W-1:0] planes_tab [8];
    bit                          user_tab [8];
    bit                          file_tab [8];
    int                          goal;
    int                          noise;
    planes_tab = '{5'd24, 5'd0, 5'd31, 5'd8, 5'd3, 5'd1, 5'd27, 5'd5};
    user_tab   = '{0, 0, 1, 0, 1, 0, 0, 0};
    file_tab   = '{0, 1, 0, 0, 1, 0, 0, 0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, shifted and unshifted palettes, unchecked entries, reads past count
    write_regs(5'd1, 1'b0, 1'b0);
    read_entry(8'd0);
    load_entry(1'b1, 8'hF0, 8'h00, 8'hA0);
    load_entry(1'b0, 8'h00, 8'h00, 8'h00);
    read_entry(8'd0);
    read_entry(8'd1);
    read_entry(8'd2);
    read_entry(8'd255);
    load_entry(1'b0, 8'h00, 8'h00, 8'h05);
    read_entry(8'd2);
    load_entry(1'b0, 8'h12, 8'h34, 8'h56);
    read_entry(8'd3);
    load_entry(1'b1, 8'hFF, 8'hFF, 8'hFF);
    read_entry(8'd0);
    load_entry(1'b0, 8'h0F, 8'hF0, 8'h0F);
    read_entry(8'd1);
    load_entry(1'b1, 8'hA0, 8'h50, 8'h30);
    read_entry(8'd0);
    settle();
    write_regs(5'd1, 1'b1, 1'b0);
    read_entry(8'd0);
    settle();
    write_regs(5'd1, 1'b0, 1'b1);
    read_entry(8'd0);
    settle();
    write_regs(5'd31, 1'b0, 1'b0);
    load_entry(1'b0, 8'h01, 8'h00, 8'h00);
    read_entry(8'd0);
    settle();
    write_regs(5'd0, 1'b0, 1'b0);
    load_entry(1'b1, 8'h00, 8'h00, 8'h00);
    load_entry(1'b0, 8'h0F, 8'h0F, 8'h0F);
    read_entry(8'd1);

    for (int p = 0; p < 8; p++) begin
      settle();
      write_regs(planes_tab[p], user_tab[p], file_tab[p]);
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 47; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 47; end
        default: begin send_pct = 20; recv_pct = 20; end
      endcase
      goal = n_items + PER_PHASE;
      if (p % 4 == 1) begin
        // overfill the store so loads get dropped
        run_palette(COLOR_DEPTH + $urandom_range(1, 6), 1'b1, $urandom_range(0, 1) * 4);
        n_full++;
      end
      while (n_items < goal) begin
        noise = $urandom_range(0, 99);
        noise = (noise < 50) ? 0 : (noise < 80) ? 5 : 60;
        run_palette(($urandom_range(0, 99) < 70) ? $urandom_range(1, 24)
                                                 : $urandom_range(25, 120),
                    $urandom_range(0, 99) < 85, noise);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d items (%0d loads, %0d reads) over %0d register settings,",
             n_items, n_loads, n_reads, n_settings);
    $display("including %0d store-full palettes; %0d mismatches", n_full, fail_count);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pge_pkg.sv
hw/rtl/pge_gun_format.sv
hw/rtl/palette_gun_expander_unit.sv
tb/sv/palette_expand_checker.sv
tb/sv/testbench.sv
